[rtl/assert_macros.svh]
// Assertion macros used by the back end of the checked ALU.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/cia_pkg.sv]
// Types and constants shared by the checked ALU modules.
package cia_pkg;
    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_FDIV = 4'd4;
    localparam logic [3:0] OP_MOD = 4'd5;
    localparam logic [3:0] OP_LT = 4'd6;
    localparam logic [3:0] OP_LE = 4'd7;
    localparam logic [3:0] OP_GT = 4'd8;
    localparam logic [3:0] OP_GE = 4'd9;
    localparam logic [3:0] OP_EQ = 4'd10;
    localparam logic [3:0] OP_NE = 4'd11;
    localparam logic [3:0] OP_MIN = 4'd12;
    localparam logic [3:0] OP_MAX = 4'd13;
    localparam logic [3:0] OP_CDIV = 4'd14;
    localparam logic [3:0] OP_NEG = 4'd15;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_DIVZERO = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_DOMAIN = 2'd3;

    // Work unit that the front end picks for an operation.
    localparam logic [1:0] UNIT_SIMPLE = 2'd0;
    localparam logic [1:0] UNIT_MUL = 2'd1;
    localparam logic [1:0] UNIT_DIV = 2'd2;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [1:0]  unit;
        logic [1:0]  pre_status;
        logic [63:0] pre_value;
        logic        a_neg;
        logic        b_neg;
        logic [63:0] a_mag;
        logic [63:0] b_mag;
    } cia_item_t;
endpackage

[rtl/checked_int64_alu.sv]
// Top level of the checked signed 64-bit ALU.
//  channel | valid       | stall       | payload
//  input   | in_valid    | in_stall    | cmd, left_operand, right_operand
//  output  | out_valid   | out_stall   | result_value, status
// One word enters per cycle while in_stall is low. With no stalls, the accepting edge
// loads the front register; the word then passes the queue, 66 back stages (one
// quotient bit per divider stage) and the output register before out_valid rises.
// Reset clears all valid flags; payload registers are not reset.
// A stall on the output halts the back pipeline; the queue lets the front
// keep taking words until it fills.
module checked_int64_alu #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [3:0]        cmd,
    input  logic signed [63:0] left_operand,
    input  logic signed [63:0] right_operand,
    output logic              out_valid,
    input  logic              out_stall,
    output logic signed [63:0] result_value,
    output logic [1:0]        status
);
    import cia_pkg::*;

    logic      fq_valid, fq_stall, qb_valid, qb_stall;
    cia_item_t fq_item, qb_item;
    logic [63:0] res;

    cia_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .cmd, .left_operand, .right_operand,
        .q_valid(fq_valid), .q_stall(fq_stall), .q_item(fq_item)
    );

    cia_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .clk, .rst_n, .wr_valid(fq_valid), .wr_stall(fq_stall), .wr_item(fq_item),
        .rd_valid(qb_valid), .rd_stall(qb_stall), .rd_item(qb_item)
    );

    cia_back u_back (
        .clk, .rst_n, .in_valid(qb_valid), .in_stall(qb_stall), .in_item(qb_item),
        .out_valid, .out_stall, .result_value(res), .status
    );

    assign result_value = res;
endmodule

[rtl/cia_front.sv]
// Front end: takes words, does the simple operations and classifies the rest.
module cia_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [3:0]        cmd,
    input  logic signed [63:0] left_operand,
    input  logic signed [63:0] right_operand,
    output logic              q_valid,
    input  logic              q_stall,
    output cia_pkg::cia_item_t q_item
);
    import cia_pkg::*;

    logic      valid_reg;
    cia_item_t item_reg;
    cia_item_t item_next;
    logic [63:0] sum;
    logic [63:0] diff;
    logic      lt;
    logic      eq;

    assign in_stall = valid_reg && q_stall;
    assign q_valid = valid_reg;
    assign q_item = item_reg;

    always_comb
    begin
        sum = left_operand + right_operand;
        diff = left_operand - right_operand;
        lt = left_operand < right_operand;
        eq = left_operand == right_operand;
        item_next = '0;
        item_next.cmd = cmd;
        item_next.unit = UNIT_SIMPLE;
        item_next.a_neg = left_operand[63];
        item_next.b_neg = right_operand[63];
        item_next.a_mag = left_operand[63] ? 64'(-left_operand) : left_operand;
        item_next.b_mag = right_operand[63] ? 64'(-right_operand) : right_operand;
        case (cmd)
            OP_ADD:
            begin
                if (left_operand[63] == right_operand[63] && sum[63] != left_operand[63])
                    item_next.pre_status = ST_OVERFLOW;
                else
                    item_next.pre_value = sum;
            end
            OP_SUB:
            begin
                if (left_operand[63] != right_operand[63] && diff[63] != left_operand[63])
                    item_next.pre_status = ST_OVERFLOW;
                else
                    item_next.pre_value = diff;
            end
            OP_MUL: item_next.unit = UNIT_MUL;
            OP_DIV, OP_FDIV, OP_MOD:
            begin
                if (right_operand == 64'd0)
                    item_next.pre_status = ST_DIVZERO;
                else if (left_operand == {1'b1, 63'd0} && right_operand == '1)
                    item_next.pre_status = ST_OVERFLOW;
                else
                    item_next.unit = UNIT_DIV;
            end
            OP_LT: item_next.pre_value = {63'd0, lt};
            OP_LE: item_next.pre_value = {63'd0, lt | eq};
            OP_GT: item_next.pre_value = {63'd0, ~(lt | eq)};
            OP_GE: item_next.pre_value = {63'd0, ~lt};
            OP_EQ: item_next.pre_value = {63'd0, eq};
            OP_NE: item_next.pre_value = {63'd0, ~eq};
            OP_MIN: item_next.pre_value = lt ? left_operand : right_operand;
            OP_MAX: item_next.pre_value = lt ? right_operand : left_operand;
            OP_CDIV:
            begin
                if (left_operand[63] || right_operand[63] || right_operand == 64'd0)
                    item_next.pre_status = ST_DOMAIN;
                else
                    item_next.unit = UNIT_DIV;
            end
            default:
            begin
                if (left_operand == {1'b1, 63'd0})
                    item_next.pre_status = ST_OVERFLOW;
                else
                    item_next.pre_value = 64'(-left_operand);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            item_reg <= item_next;
    end
endmodule

[rtl/cia_fifo.sv]
// Short queue of classified words between the front and back ends.
module cia_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_stall,
    input  cia_pkg::cia_item_t wr_item,
    output logic              rd_valid,
    input  logic              rd_stall,
    output cia_pkg::cia_item_t rd_item
);
    import cia_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cia_item_t   mem [DEPTH];
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] rp_reg;
    logic [AW:0]   cnt_reg;
    logic          push;
    logic          pop;

    assign wr_stall = cnt_reg == (AW+1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_item = mem[rp_reg];
    assign push = wr_valid && !wr_stall;
    assign pop = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= wr_item;
    end
endmodule

[rtl/cia_back.sv]
// Back end: pipelined multiply and one-bit-a-stage divide, in word order.
module cia_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  cia_pkg::cia_item_t in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [63:0]       result_value,
    output logic [1:0]        status
);
    import cia_pkg::*;
    `include "assert_macros.svh"

    // Stage 0 takes the word; stages 1..64 each retire one quotient bit and, in
    // parallel, the product is built from four 32x32 partial products.
    localparam int NS = 66;

    logic        adv;
    logic        v_reg   [NS];
    cia_item_t   it_reg  [NS];
    logic [63:0] rem_reg [NS];
    logic [63:0] quo_reg [NS];
    logic [63:0] pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [127:0] prod_reg;
    logic [63:0] res_fin;
    logic [1:0]  st_fin;
    logic        out_v_reg;
    logic [63:0] out_val_reg;
    logic [1:0]  out_st_reg;

    // The whole pipeline moves together; a free output slot lets it advance.
    assign adv = !out_v_reg || !out_stall;
    assign in_stall = !adv;
    assign out_valid = out_v_reg;
    assign result_value = out_val_reg;
    assign status = out_st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
                v_reg[i] <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                v_reg[i] <= v_reg[i-1];
            out_v_reg <= v_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it_reg[0] <= in_item;
            rem_reg[0] <= '0;
            quo_reg[0] <= in_item.a_mag;
            for (int i = 1; i < 65; i++)
            begin
                logic [64:0] trial;
                trial = {rem_reg[i-1], quo_reg[i-1][63]} - {1'b0, it_reg[i-1].b_mag};
                it_reg[i] <= it_reg[i-1];
                if (!trial[64])
                begin
                    rem_reg[i] <= trial[63:0];
                    quo_reg[i] <= {quo_reg[i-1][62:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= {rem_reg[i-1][62:0], quo_reg[i-1][63]};
                    quo_reg[i] <= {quo_reg[i-1][62:0], 1'b0};
                end
            end
            it_reg[65] <= it_reg[64];
            rem_reg[65] <= rem_reg[64];
            quo_reg[65] <= quo_reg[64];
            pp_ll_reg <= in_item.a_mag[31:0] * in_item.b_mag[31:0];
            pp_lh_reg <= in_item.a_mag[31:0] * in_item.b_mag[63:32];
            pp_hl_reg <= in_item.a_mag[63:32] * in_item.b_mag[31:0];
            pp_hh_reg <= in_item.a_mag[63:32] * in_item.b_mag[63:32];
            prod_reg <= {64'd0, pp_ll_reg} + {32'd0, pp_lh_reg, 32'd0}
                      + {32'd0, pp_hl_reg, 32'd0} + {pp_hh_reg, 64'd0};
            out_val_reg <= res_fin;
            out_st_reg <= st_fin;
        end
    end

    // The product is aligned with stage 1, so it is carried to the end.
    logic [127:0] prod_pipe_reg [NS-2];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_pipe_reg[0] <= prod_reg;
            for (int i = 1; i < NS-2; i++)
                prod_pipe_reg[i] <= prod_pipe_reg[i-1];
        end
    end

    always_comb
    begin
        cia_item_t   it;
        logic [127:0] p;
        logic        neg;
        logic [63:0] q;
        logic [63:0] r;
        logic        rnz;
        it = it_reg[NS-1];
        p = prod_pipe_reg[NS-3];
        neg = it.a_neg ^ it.b_neg;
        q = quo_reg[NS-1];
        r = rem_reg[NS-1];
        rnz = r != '0;
        res_fin = it.pre_value;
        st_fin = it.pre_status;
        if (it.unit == UNIT_MUL)
        begin
            if (p[127:64] != '0 || (neg ? p[63:0] > {1'b1, 63'd0} : p[63]))
            begin
                st_fin = ST_OVERFLOW;
                res_fin = '0;
            end
            else
                res_fin = neg ? 64'(-p[63:0]) : p[63:0];
        end
        else if (it.unit == UNIT_DIV)
        begin
            case (it.cmd)
                OP_MOD: res_fin = it.a_neg ? 64'(-r) : r;
                OP_CDIV: res_fin = q + {63'd0, rnz};
                OP_FDIV: res_fin = neg ? 64'(-q) - {63'd0, rnz} : q;
                default: res_fin = neg ? 64'(-q) : q;
            endcase
        end
    end

    `ASSERT_IMPLIES(a_err_zero, clk, rst_n, out_v_reg && out_st_reg != ST_OK,
        out_val_reg == '0)
    `ASSERT_NEXT(a_hold, clk, rst_n, out_v_reg && out_stall,
        out_v_reg && $stable(out_val_reg) && $stable(out_st_reg))
    `ASSERT_IMPLIES(a_stall_full, clk, rst_n, in_stall, out_v_reg)
endmodule
